// ----- sv/bag_pkg.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// bag_pkg
// Shared types, codes and helper functions of the Bruck allgather scheduler.
// ---------------------------------------------------------------------------
package bag_pkg;

	localparam logic [16:0] MAX_MEMBERS = 17'd1024;
	localparam logic [15:0] COUNT_MAX   = 16'd4095;

	localparam int N_W      = 11;
	localparam int RANK_W   = 10;
	localparam int DIST_W   = 4;
	localparam int CNT_W    = 12;
	localparam int NUM_DIST = 11;
	localparam int CFG_W    = 11;
	localparam int CFG_IDX_W = 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MEMBER_COUNT = 1'd0,
		CFG_MY_RANK      = 1'd1
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ACT_SEND     = 2'd0,
		ACT_ABSORB   = 2'd1,
		ACT_HOLD     = 2'd2,
		ACT_COMPLETE = 2'd3
	} action_t;

	typedef struct packed {
		logic              mode;
		logic [DIST_W-1:0] distance;
		logic [CNT_W-1:0]  count;
	} item_t;

	typedef struct packed {
		action_t           action;
		logic [RANK_W-1:0] peer_rank;
		logic [DIST_W-1:0] distance_res;
		logic [CNT_W-1:0]  count_res;
		logic              last;
	} res_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_DIV,
		OP_START,
		OP_ABSORB_IN,
		OP_HOLD_IN,
		OP_SEND,
		OP_SEND_FINAL,
		OP_TAKE,
		OP_COMPLETE,
		OP_FLUSH
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} cmd_t;

	typedef struct packed {
		logic mode;
		logic div_last;
		logic ignore;
		logic arr_ready;
		logic d_lt_l;
		logic d_eq_l;
		logic d_gt_l;
		logic final_here;
		logic held_here;
		logic done_cnt;
		logic pend_valid;
		logic emit_ok;
	} sts_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_DECIDE,
		ST_SEND,
		ST_FINAL,
		ST_TAKE,
		ST_CHECK,
		ST_FLUSH
	} state_t;

	function automatic logic [DIST_W-1:0] floor_log2(input logic [N_W-1:0] n);
		logic [DIST_W-1:0] k;
		k = '0;
		for (int i = 0; i < N_W; i++) begin
			if (n[i]) begin
				k = DIST_W'(i);
			end
		end
		return k;
	endfunction

	function automatic logic [DIST_W-1:0] ceil_log2(input logic [N_W-1:0] r);
		logic [DIST_W-1:0] k;
		k = DIST_W'(N_W - 1);
		for (int i = N_W - 1; i >= 0; i--) begin
			if ((N_W'(1) << i) >= r) begin
				k = DIST_W'(i);
			end
		end
		return k;
	endfunction

	function automatic logic [CNT_W-1:0] sat_count(input logic [CNT_W-1:0] c);
		logic [CNT_W-1:0] s;
		s = (16'(c) > COUNT_MAX) ? CNT_W'(COUNT_MAX) : c;
		return s;
	endfunction

	function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
		input logic [CNT_W-1:0] b);
		logic [16:0] s;
		logic [CNT_W-1:0] r;
		s = 17'(a) + 17'(b);
		r = (s > 17'(COUNT_MAX)) ? CNT_W'(COUNT_MAX) : CNT_W'(s);
		return r;
	endfunction

endpackage
`default_nettype wire

// ----- sv/bruck_allgather_scheduler_core.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// bruck_allgather_scheduler_core
// Bruck allgather round scheduler: turns starts and arrivals into actions.
// ---------------------------------------------------------------------------
// Usage:
//   item channel (item_valid/item_stall/item) takes a start or an arrival word.
//   res channel (res_valid/res_stall/res) delivers the actions it causes, in
//   order; res.last marks the final action of a word. An arrival that is out
//   of range or already absorbed produces no action.
//   cfg_write_en/cfg_index/cfg_wdata write member_count and my_rank; write
//   only while no word is in flight.
// Timing:
//   one word at a time; item_stall is high from acceptance until the sequencer
//   is idle again. It forms the rank remainder, then decides; a start or an
//   absorbed arrival then walks the rounds (send, final send, take of a held
//   count), checks for completion and flushes the last action.
//   Actions are staged one deep and then registered, so a stalled receiver
//   just freezes the sequencer; nothing is dropped.
// Reset: clears all gather state, member_count to 1 and my_rank to 0.
// ---------------------------------------------------------------------------
module bruck_allgather_scheduler_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_write_en,
	input  wire logic [bag_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [bag_pkg::CFG_W-1:0]     cfg_wdata,
	input  wire logic                          item_valid,
	output logic                               item_stall,
	input  wire bag_pkg::item_t                item,
	output logic                               res_valid,
	input  wire logic                          res_stall,
	output bag_pkg::res_t                      res
);
	import bag_pkg::*;

	cmd_t cmd;
	sts_t sts;

	bag_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.sts        (sts),
		.cmd        (cmd)
	);

	bag_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.item         (item),
		.res          (res),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.cmd          (cmd),
		.sts          (sts)
	);

endmodule
`default_nettype wire

// ----- sv/bag_rank_mod.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// bag_rank_mod
// Restoring remainder unit: rank modulo member count, one bit per cycle.
// ---------------------------------------------------------------------------
module bag_rank_mod (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic                       step,
	input  wire logic [bag_pkg::RANK_W-1:0] rank,
	input  wire logic [bag_pkg::N_W-1:0]    divisor,
	output logic      [bag_pkg::RANK_W-1:0] rem,
	output logic                            last
);
	import bag_pkg::*;

	logic [RANK_W-1:0] rem_q;
	logic [3:0]        cnt_q;
	logic [3:0]        bit_idx;
	logic [N_W-1:0]    shifted;
	logic [N_W-1:0]    reduced;

	always_comb begin
		bit_idx = 4'(RANK_W - 1) - cnt_q;
		shifted = {rem_q, rank[bit_idx]};
		reduced = (shifted >= divisor) ? (shifted - divisor) : shifted;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
			cnt_q <= '0;
		end else if (start) begin
			rem_q <= '0;
			cnt_q <= '0;
		end else if (step) begin
			rem_q <= RANK_W'(reduced);
			cnt_q <= cnt_q + 4'd1;
		end
	end

	assign rem  = rem_q;
	assign last = (cnt_q == 4'(RANK_W - 1));

endmodule
`default_nettype wire

// ----- sv/bag_dpath.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// bag_dpath
// Datapath: configuration, gather state, held counts, result staging.
// ---------------------------------------------------------------------------
module bag_dpath (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_write_en,
	input  wire logic [bag_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [bag_pkg::CFG_W-1:0] cfg_wdata,
	input  wire bag_pkg::item_t            item,
	output bag_pkg::res_t                  res,
	output logic                           res_valid,
	input  wire logic                      res_stall,
	input  wire bag_pkg::cmd_t             cmd,
	output bag_pkg::sts_t                  sts
);
	import bag_pkg::*;

	// configuration
	logic [N_W-1:0]    member_count_q;
	logic [RANK_W-1:0] my_rank_q;

	// per-item copies
	item_t             item_q;
	logic [N_W-1:0]    n_q;
	logic [DIST_W-1:0] lvl_q;
	logic              has_final_q;
	logic [DIST_W-1:0] last_round_q;

	// gather state
	logic [CNT_W-1:0]    g_q;
	logic [NUM_DIST-1:0] recv_q;
	logic [NUM_DIST-1:0] held_q;
	logic [CNT_W-1:0]    held_cnt_q [NUM_DIST];
	logic [DIST_W-1:0]   d_q;

	// result staging
	res_t pend_q;
	logic pend_valid_q;
	res_t res_q;
	logic res_valid_q;

	logic [N_W-1:0]      n_eff;
	logic [N_W-1:0]      n_rem;
	logic [RANK_W-1:0]   rank_mod;
	logic                div_last;
	logic [DIST_W-1:0]   in_d;
	logic                in_le_l;
	logic                pred_in;
	logic [CNT_W-1:0]    add_b;
	logic [CNT_W-1:0]    g_sum;
	logic [DIST_W-1:0]   peer_dist;
	logic [CNT_W-1:0]    peer_tmp;
	logic [RANK_W-1:0]   peer;
	logic                emit;
	res_t                new_res;
	logic                push;
	res_t                push_res;
	logic                out_free;

	bag_rank_mod u_rank_mod (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.op == OP_LOAD),
		.step    (cmd.op == OP_DIV),
		.rank    (my_rank_q),
		.divisor (n_q),
		.rem     (rank_mod),
		.last    (div_last)
	);

	always_comb begin
		if (member_count_q == '0) begin
			n_eff = N_W'(1);
		end else if (17'(member_count_q) > MAX_MEMBERS) begin
			n_eff = N_W'(MAX_MEMBERS);
		end else begin
			n_eff = member_count_q;
		end
		n_rem = n_eff - (N_W'(1) << floor_log2(n_eff));
	end

	always_comb begin
		in_d    = item_q.distance;
		in_le_l = (in_d <= lvl_q);
		pred_in = in_le_l && ((in_d == '0) || recv_q[in_d - 4'd1]);
		add_b   = (cmd.op == OP_TAKE) ? held_cnt_q[d_q] : item_q.count;
		g_sum   = sat_add(g_q, add_b);

		// (n + rank - 2^d) stays below 2n, so one subtract wraps it
		peer_dist = (cmd.op == OP_SEND_FINAL) ? lvl_q : d_q;
		peer_tmp  = CNT_W'(n_q) + CNT_W'(rank_mod) - (CNT_W'(1) << peer_dist);
		if (peer_tmp >= CNT_W'(n_q)) begin
			peer_tmp = peer_tmp - CNT_W'(n_q);
		end
		peer = RANK_W'(peer_tmp);

		emit    = 1'b1;
		new_res = '{action: ACT_SEND, peer_rank: peer, distance_res: d_q,
			count_res: g_q, last: 1'b0};
		unique case (cmd.op)
			OP_ABSORB_IN: begin
				new_res.action       = ACT_ABSORB;
				new_res.peer_rank    = '0;
				new_res.distance_res = in_d;
				new_res.count_res    = g_sum;
			end
			OP_HOLD_IN: begin
				new_res.action       = ACT_HOLD;
				new_res.peer_rank    = '0;
				new_res.distance_res = in_d;
				new_res.count_res    = item_q.count;
			end
			OP_SEND: begin
			end
			OP_SEND_FINAL: begin
				new_res.distance_res = lvl_q;
			end
			OP_TAKE: begin
				new_res.action    = ACT_ABSORB;
				new_res.peer_rank = '0;
				new_res.count_res = g_sum;
			end
			OP_COMPLETE: begin
				new_res.action       = ACT_COMPLETE;
				new_res.peer_rank    = '0;
				new_res.distance_res = '0;
			end
			default: begin
				emit = 1'b0;
			end
		endcase

		out_free = !res_valid_q || !res_stall;
		push     = pend_valid_q && (emit || (cmd.op == OP_FLUSH));
		push_res = pend_q;
		push_res.last = (cmd.op == OP_FLUSH);
	end

	always_comb begin
		sts.mode       = item_q.mode;
		sts.div_last   = div_last;
		sts.ignore     = !in_le_l || recv_q[in_d];
		sts.arr_ready  = (g_q != '0) && pred_in;
		sts.d_lt_l     = (d_q < lvl_q);
		sts.d_eq_l     = (d_q == lvl_q);
		sts.d_gt_l     = (d_q > lvl_q);
		sts.final_here = has_final_q && (d_q == last_round_q);
		sts.held_here  = (d_q <= DIST_W'(NUM_DIST - 1)) && held_q[d_q];
		sts.done_cnt   = (g_q >= CNT_W'(n_q));
		sts.pend_valid = pend_valid_q;
		sts.emit_ok    = !pend_valid_q || out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			member_count_q <= N_W'(1);
			my_rank_q      <= '0;
		end else if (cfg_write_en) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_MEMBER_COUNT: member_count_q <= cfg_wdata;
				CFG_MY_RANK:      my_rank_q      <= cfg_wdata[RANK_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			g_q          <= '0;
			recv_q       <= '0;
			held_q       <= '0;
			d_q          <= '0;
			n_q          <= N_W'(1);
			lvl_q        <= '0;
			has_final_q  <= 1'b0;
			last_round_q <= '0;
			pend_valid_q <= 1'b0;
			res_valid_q  <= 1'b0;
		end else begin
			unique case (cmd.op)
				OP_LOAD: begin
					n_q          <= n_eff;
					lvl_q        <= floor_log2(n_eff);
					has_final_q  <= (n_rem != '0);
					last_round_q <= ceil_log2(n_rem);
				end
				OP_START: begin
					g_q    <= CNT_W'(1);
					recv_q <= '0;
					d_q    <= '0;
				end
				OP_ABSORB_IN: begin
					g_q    <= g_sum;
					recv_q <= recv_q | (NUM_DIST'(1) << in_d);
					d_q    <= in_d + 4'd1;
				end
				OP_HOLD_IN: begin
					held_q <= held_q | (NUM_DIST'(1) << in_d);
				end
				OP_TAKE: begin
					g_q    <= g_sum;
					recv_q <= recv_q | (NUM_DIST'(1) << d_q);
					held_q <= held_q & ~(NUM_DIST'(1) << d_q);
					d_q    <= d_q + 4'd1;
				end
				OP_COMPLETE: begin
					g_q    <= '0;
					recv_q <= '0;
					held_q <= '0;
				end
				default: begin
				end
			endcase

			if (emit) begin
				pend_valid_q <= 1'b1;
			end else if (cmd.op == OP_FLUSH) begin
				pend_valid_q <= 1'b0;
			end

			if (push) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_LOAD) begin
			item_q <= '{mode: item.mode, distance: item.distance,
				count: sat_count(item.count)};
		end
		if (cmd.op == OP_HOLD_IN) begin
			held_cnt_q[in_d] <= item_q.count;
		end
		if (emit) begin
			pend_q <= new_res;
		end
		if (push) begin
			res_q <= push_res;
		end
	end

	assign res       = res_q;
	assign res_valid = res_valid_q;

`ifndef ASSERT_OFF
	// a staged word never overwrites one the receiver has not taken
	assert property (@(posedge clk) disable iff (!arst_n)
		(push && res_valid_q) |-> !res_stall)
		else $error("result overwritten while stalled");

	// nothing is marked absorbed unless a collective is running
	assert property (@(posedge clk) disable iff (!arst_n)
		(g_q == '0) |-> (recv_q == '0))
		else $error("received mask set with no gathered count");
`endif

endmodule
`default_nettype wire

// ----- sv/bag_ctrl.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// bag_ctrl
// Sequencer: walks one item through setup, rounds, completion and flush.
// ---------------------------------------------------------------------------
module bag_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          item_valid,
	output logic               item_stall,
	input  wire bag_pkg::sts_t sts,
	output bag_pkg::cmd_t      cmd
);
	import bag_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (sts.div_last) begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				priority if (!sts.mode) begin
					state_d = ST_SEND;
				end else if (sts.ignore) begin
					state_d = ST_IDLE;
				end else if (sts.emit_ok) begin
					state_d = sts.arr_ready ? ST_SEND : ST_FLUSH;
				end
			end
			ST_SEND: begin
				priority if (sts.d_gt_l) begin
					state_d = ST_CHECK;
				end else if (sts.d_eq_l || sts.emit_ok) begin
					state_d = sts.final_here ? ST_FINAL : ST_TAKE;
				end
			end
			ST_FINAL: begin
				if (sts.emit_ok) begin
					state_d = ST_TAKE;
				end
			end
			ST_TAKE: begin
				priority if (!sts.held_here) begin
					state_d = ST_CHECK;
				end else if (sts.emit_ok) begin
					state_d = sts.d_lt_l ? ST_SEND : ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (!sts.done_cnt || sts.emit_ok) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				if (sts.emit_ok) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		item_stall = (state_q != ST_IDLE);
		cmd.op     = OP_NONE;
		unique case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					cmd.op = OP_LOAD;
				end
			end
			ST_DIV: begin
				cmd.op = OP_DIV;
			end
			ST_DECIDE: begin
				priority if (!sts.mode) begin
					cmd.op = OP_START;
				end else if (sts.ignore) begin
					cmd.op = OP_NONE;
				end else if (sts.emit_ok) begin
					cmd.op = sts.arr_ready ? OP_ABSORB_IN : OP_HOLD_IN;
				end
			end
			ST_SEND: begin
				if (sts.d_lt_l && sts.emit_ok) begin
					cmd.op = OP_SEND;
				end
			end
			ST_FINAL: begin
				if (sts.emit_ok) begin
					cmd.op = OP_SEND_FINAL;
				end
			end
			ST_TAKE: begin
				if (sts.held_here && sts.emit_ok) begin
					cmd.op = OP_TAKE;
				end
			end
			ST_CHECK: begin
				if (sts.done_cnt && sts.emit_ok) begin
					cmd.op = OP_COMPLETE;
				end
			end
			ST_FLUSH: begin
				if (sts.emit_ok) begin
					cmd.op = OP_FLUSH;
				end
			end
			default: begin
				cmd.op = OP_NONE;
			end
		endcase
	end

`ifndef ASSERT_OFF
	// the last word of an item is always flushed before the next is taken
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !sts.pend_valid)
		else $error("pending word left behind in idle");

	// a word is staged only when the staging slot can move on
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_ABSORB_IN || cmd.op == OP_HOLD_IN || cmd.op == OP_SEND ||
		 cmd.op == OP_SEND_FINAL || cmd.op == OP_TAKE || cmd.op == OP_COMPLETE ||
		 cmd.op == OP_FLUSH) |-> sts.emit_ok)
		else $error("word staged while output blocked");
`endif

endmodule
`default_nettype wire
